@@ hw/rtl/dla_pkg.sv @@
// Shared types, codes and constants of the dense layer unit.
// Also holds the exp(y)-1 table used by the ELU activation.
// No dependencies.
package dla_pkg;

	localparam int DATA_WIDTH  = 16;
	localparam int MAX_INPUTS  = 64;
	localparam int MAX_NEURONS = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int ACC_W       = 40;
	localparam int WADDR_W     = 2 * IDX_W;
	localparam int PROD_W      = 2 * DATA_WIDTH;

	localparam logic [1:0] KIND_WEIGHT  = 2'd0;
	localparam logic [1:0] KIND_BIAS    = 2'd1;
	localparam logic [1:0] KIND_ELEMENT = 2'd2;

	localparam logic [1:0] ACT_LINEAR = 2'd0;
	localparam logic [1:0] ACT_RELU   = 2'd1;
	localparam logic [1:0] ACT_ELU    = 2'd2;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_NIN  = 2'd1;
	localparam logic [1:0] CFG_NN   = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MAC   = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_FRD   = 6'b001000,
		ST_FSUM  = 6'b010000,
		ST_FACT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] nrn;
	} mac_tag_t;

	typedef struct packed {
		logic                         w_en;
		logic                         b_en;
		logic [WADDR_W-1:0]           waddr;
		logic [IDX_W-1:0]             baddr;
		logic signed [DATA_WIDTH-1:0] data;
	} store_wr_t;

	typedef logic signed [DATA_WIDTH-1:0] elu_tab_t [0:255];

	// Entry i holds round(256 * exp(-(256 - i) / 32)) - 256, built in Q32 steps
	function automatic elu_tab_t build_elu_table();
		elu_tab_t    t;
		logic [63:0] v;
		logic [63:0] r;
		v = 64'h1_0000_0000;
		for (int k = 1; k <= 256; k++) begin
			v = (v * 64'd4162825044 + 64'h8000_0000) >> 32;
			r = (v + 64'h80_0000) >> 24;
			t[256 - k] = $signed(r[DATA_WIDTH-1:0]) - 16'sd256;
		end
		return t;
	endfunction

	localparam elu_tab_t ELU_TABLE = build_elu_table();

endpackage

@@ hw/rtl/dla_store.sv @@
// Weight and bias stores of the dense layer unit, one write and one read port each.
// Read data is registered. Depends on dla_pkg.
module dla_store (
	input  logic                                 clk,
	input  dla_pkg::store_wr_t                   wr,
	input  logic [dla_pkg::WADDR_W-1:0]          w_raddr,
	input  logic [dla_pkg::IDX_W-1:0]            b_raddr,
	output logic signed [dla_pkg::DATA_WIDTH-1:0] w_rdata,
	output logic signed [dla_pkg::DATA_WIDTH-1:0] b_rdata
);

	logic signed [dla_pkg::DATA_WIDTH-1:0] weight_mem [dla_pkg::MAX_INPUTS*dla_pkg::MAX_NEURONS];
	logic signed [dla_pkg::DATA_WIDTH-1:0] bias_mem [dla_pkg::MAX_NEURONS];

	always_ff @(posedge clk) begin
		if (wr.w_en) begin
			weight_mem[wr.waddr] <= wr.data;
		end
		w_rdata <= weight_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.b_en) begin
			bias_mem[wr.baddr] <= wr.data;
		end
		b_rdata <= bias_mem[b_raddr];
	end

endmodule

@@ hw/rtl/dla_mac.sv @@
// Shared multiply-accumulate unit: registered product, then a 40-bit wrapping add.
// Depends on dla_pkg.
module dla_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dla_pkg::mac_tag_t                     tag_s1,
	input  logic signed [dla_pkg::DATA_WIDTH-1:0] w_s1,
	input  logic signed [dla_pkg::DATA_WIDTH-1:0] x,
	input  logic [dla_pkg::ACC_W-1:0]             acc_s1,
	output dla_pkg::mac_tag_t                     tag_s2,
	output logic [dla_pkg::ACC_W-1:0]             sum_s2
);

	logic signed [dla_pkg::PROD_W-1:0] prod_s2;
	logic [dla_pkg::ACC_W-1:0]         acc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * x;
		acc_s2  <= acc_s1;
	end

	assign sum_s2 = acc_s2 + {{(dla_pkg::ACC_W-dla_pkg::PROD_W){prod_s2[dla_pkg::PROD_W-1]}},
		prod_s2};

endmodule

@@ hw/rtl/dla_act.sv @@
// Output stage logic: round the accumulator sum to Q8.8, saturate, apply activation.
// Depends on dla_pkg for codes and the ELU table.
module dla_act (
	input  logic [dla_pkg::ACC_W-1:0]             sum,
	input  logic [1:0]                            mode,
	output logic signed [dla_pkg::DATA_WIDTH-1:0] result
);

	logic [dla_pkg::ACC_W:0]               rnd;
	logic [dla_pkg::ACC_W-8:0]             q;
	logic signed [dla_pkg::DATA_WIDTH-1:0] y;
	logic                                  fits;

	always_comb begin
		rnd  = {sum[dla_pkg::ACC_W-1], sum} + (dla_pkg::ACC_W+1)'(128);
		q    = rnd[dla_pkg::ACC_W:8];
		fits = (q[dla_pkg::ACC_W-8:dla_pkg::DATA_WIDTH-1] == '0) ||
			(q[dla_pkg::ACC_W-8:dla_pkg::DATA_WIDTH-1] == '1);
		if (fits) begin
			y = $signed(q[dla_pkg::DATA_WIDTH-1:0]);
		end else if (q[dla_pkg::ACC_W-8]) begin
			y = {1'b1, {(dla_pkg::DATA_WIDTH-1){1'b0}}};
		end else begin
			y = {1'b0, {(dla_pkg::DATA_WIDTH-1){1'b1}}};
		end

		result = y;
		case (mode)
			dla_pkg::ACT_RELU: begin
				if (y[dla_pkg::DATA_WIDTH-1]) begin
					result = '0;
				end
			end
			dla_pkg::ACT_ELU: begin
				if (y[dla_pkg::DATA_WIDTH-1]) begin
					if (y[dla_pkg::DATA_WIDTH-1:11] != '1) begin
						result = -16'sd256;
					end else begin
						result = dla_pkg::ELU_TABLE[y[10:3]];
					end
				end
			end
			default: result = y;
		endcase
	end

endmodule

@@ hw/rtl/dense_layer_with_activation_unit.sv @@
// Top level of the dense layer unit: sequencer, accumulator store, configuration.
// Depends on dla_pkg, dla_store, dla_mac and dla_act.
//
// A weight, bias or unknown-kind item leaves the block ready for the next item. An input element
// keeps it busy: one shared multiply-accumulate unit visits each neuron
// once, paced by the single read port of the weight and accumulator stores, and
// the pipeline drains before the next item. The element that completes a vector
// then steps each neuron through FRD, FSUM and FACT for the bias, rounding and
// activation of its result, waiting in FACT while the output stalls. The output
// register holds the final result while the block already accepts new items.
module dense_layer_with_activation_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            kind,
	input  logic [dla_pkg::IDX_W-1:0]             row_index,
	input  logic [dla_pkg::IDX_W-1:0]             neuron_index,
	input  logic signed [dla_pkg::DATA_WIDTH-1:0] value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dla_pkg::IDX_W-1:0]             out_neuron,
	output logic signed [dla_pkg::DATA_WIDTH-1:0] out_value,
	output logic                                  out_last,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [dla_pkg::CNT_W-1:0]             cfg_data
);

	dla_pkg::state_t                       state_q;
	logic [dla_pkg::IDX_W-1:0]             n_q;
	logic [dla_pkg::IDX_W-1:0]             cnt_q;
	logic signed [dla_pkg::DATA_WIDTH-1:0] x_q;
	logic [1:0]                            mode_q;
	logic [dla_pkg::CNT_W-1:0]             nin_q;
	logic [dla_pkg::CNT_W-1:0]             nn_q;
	logic [dla_pkg::CNT_W-1:0]             nin_eff;
	logic [dla_pkg::CNT_W-1:0]             nn_eff;
	logic                                  last_n;
	logic                                  vec_done;
	logic                                  in_xfer;
	logic                                  out_load;

	logic [dla_pkg::ACC_W-1:0]             acc_mem [dla_pkg::MAX_NEURONS];
	logic [dla_pkg::MAX_NEURONS-1:0]       acc_vld_q;
	logic [dla_pkg::ACC_W-1:0]             acc_rd_s1;
	logic                                  accv_s1;
	logic [dla_pkg::ACC_W-1:0]             acc_op_s1;
	logic [dla_pkg::ACC_W-1:0]             sum_q;

	dla_pkg::store_wr_t                    st_wr;
	logic signed [dla_pkg::DATA_WIDTH-1:0] w_rd_s1;
	logic signed [dla_pkg::DATA_WIDTH-1:0] b_rd_s1;
	dla_pkg::mac_tag_t                     tag_s1;
	dla_pkg::mac_tag_t                     tag_s2;
	logic [dla_pkg::ACC_W-1:0]             mac_sum_s2;
	logic signed [dla_pkg::DATA_WIDTH-1:0] act_val;

	logic                                  out_valid_q;
	logic [dla_pkg::IDX_W-1:0]             out_neuron_q;
	logic signed [dla_pkg::DATA_WIDTH-1:0] out_value_q;
	logic                                  out_last_q;

	assign in_stall   = (state_q != dla_pkg::ST_IDLE);
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign out_neuron = out_neuron_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

	always_comb begin
		if (nin_q == '0) begin
			nin_eff = dla_pkg::CNT_W'(1);
		end else if (nin_q > dla_pkg::CNT_W'(dla_pkg::MAX_INPUTS)) begin
			nin_eff = dla_pkg::CNT_W'(dla_pkg::MAX_INPUTS);
		end else begin
			nin_eff = nin_q;
		end
		if (nn_q == '0) begin
			nn_eff = dla_pkg::CNT_W'(1);
		end else if (nn_q > dla_pkg::CNT_W'(dla_pkg::MAX_NEURONS)) begin
			nn_eff = dla_pkg::CNT_W'(dla_pkg::MAX_NEURONS);
		end else begin
			nn_eff = nn_q;
		end
	end

	assign last_n   = ({1'b0, n_q} == nn_eff - dla_pkg::CNT_W'(1));
	assign vec_done = ({1'b0, cnt_q} + dla_pkg::CNT_W'(1)) >= nin_eff;
	assign out_load = (state_q == dla_pkg::ST_FACT) && (!out_valid_q || !out_stall);

	always_comb begin
		st_wr.w_en  = in_xfer && (kind == dla_pkg::KIND_WEIGHT);
		st_wr.b_en  = in_xfer && (kind == dla_pkg::KIND_BIAS);
		st_wr.waddr = {row_index, neuron_index};
		st_wr.baddr = neuron_index;
		st_wr.data  = value;
	end

	dla_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.w_raddr ({cnt_q, n_q}),
		.b_raddr (n_q),
		.w_rdata (w_rd_s1),
		.b_rdata (b_rd_s1)
	);

	assign acc_op_s1 = accv_s1 ? acc_rd_s1 : '0;

	dla_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (tag_s1),
		.w_s1   (w_rd_s1),
		.x      (x_q),
		.acc_s1 (acc_op_s1),
		.tag_s2 (tag_s2),
		.sum_s2 (mac_sum_s2)
	);

	dla_act u_act (
		.sum    (sum_q),
		.mode   (mode_q),
		.result (act_val)
	);

	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_mem[tag_s2.nrn] <= mac_sum_s2;
		end
		acc_rd_s1 <= acc_mem[n_q];
		accv_s1   <= acc_vld_q[n_q];
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= value;
		end
		if (state_q == dla_pkg::ST_FSUM) begin
			sum_q <= acc_op_s1 + {{(dla_pkg::ACC_W-dla_pkg::DATA_WIDTH-8){b_rd_s1[dla_pkg::DATA_WIDTH-1]}},
				b_rd_s1, 8'h00};
		end
		if (out_load) begin
			out_neuron_q <= n_q;
			out_value_q  <= act_val;
			out_last_q   <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dla_pkg::ACT_LINEAR;
			nin_q  <= dla_pkg::CNT_W'(1);
			nn_q   <= dla_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dla_pkg::CFG_MODE: mode_q <= cfg_data[1:0];
				dla_pkg::CFG_NIN:  nin_q  <= cfg_data;
				dla_pkg::CFG_NN:   nn_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dla_pkg::ST_IDLE;
			n_q       <= '0;
			cnt_q     <= '0;
			tag_s1    <= '0;
			acc_vld_q <= '0;
		end else begin
			tag_s1.vld <= (state_q == dla_pkg::ST_MAC);
			tag_s1.nrn <= n_q;
			if (tag_s2.vld) begin
				acc_vld_q[tag_s2.nrn] <= 1'b1;
			end
			unique case (state_q)
				dla_pkg::ST_IDLE: begin
					n_q <= '0;
					if (in_xfer && kind == dla_pkg::KIND_ELEMENT) begin
						state_q <= dla_pkg::ST_MAC;
					end
				end
				dla_pkg::ST_MAC: begin
					if (last_n) begin
						n_q     <= '0;
						state_q <= dla_pkg::ST_DRAIN;
					end else begin
						n_q <= n_q + dla_pkg::IDX_W'(1);
					end
				end
				dla_pkg::ST_DRAIN: begin
					if (!tag_s1.vld && !tag_s2.vld) begin
						if (vec_done) begin
							cnt_q   <= '0;
							state_q <= dla_pkg::ST_FRD;
						end else begin
							cnt_q   <= cnt_q + dla_pkg::IDX_W'(1);
							state_q <= dla_pkg::ST_IDLE;
						end
					end
				end
				dla_pkg::ST_FRD: begin
					state_q <= dla_pkg::ST_FSUM;
				end
				dla_pkg::ST_FSUM: begin
					state_q <= dla_pkg::ST_FACT;
				end
				dla_pkg::ST_FACT: begin
					if (out_load) begin
						if (last_n) begin
							acc_vld_q <= '0;
							n_q       <= '0;
							state_q   <= dla_pkg::ST_IDLE;
						end else begin
							n_q     <= n_q + dla_pkg::IDX_W'(1);
							state_q <= dla_pkg::ST_FRD;
						end
					end
				end
				default: state_q <= dla_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/dla_checker.sv @@
// Port-level checks of the dense layer unit, attached to the top level by bind.
// Depends on dla_pkg and dense_layer_with_activation_unit.
module dla_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic [1:0]                            kind,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [dla_pkg::IDX_W-1:0]             out_neuron,
	input logic signed [dla_pkg::DATA_WIDTH-1:0] out_value,
	input logic                                  out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) &&
			$stable(out_neuron) && $stable(out_last))
		else $error("stalled result changed");

	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind != dla_pkg::KIND_ELEMENT |=> !in_stall)
		else $error("store write or ignored transfer made the block busy");

	a_element_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == dla_pkg::KIND_ELEMENT |=> in_stall)
		else $error("element transfer did not start the accumulate pass");

	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_stall |-> out_last)
		else $error("block idle with a result other than the last pending");

endmodule

bind dense_layer_with_activation_unit dla_checker u_dla_checker (.*);

@@ sim/tb.sv @@
// Self-checking bench for the dense layer unit: loads weights and biases, streams vectors
// and checks every neuron result against an in-bench fixed-point model of the layer.
// Depends on dla_pkg and dense_layer_with_activation_unit.
`timescale 1ns / 1ps

typedef struct packed {
	logic [dla_pkg::IDX_W-1:0]             nrn;
	logic signed [dla_pkg::DATA_WIDTH-1:0] val;
	logic                                  last;
} neuron_out_t;

class dense_layer_predictor;
	logic signed [15:0] weights [0:4095];
	logic signed [15:0] biases [0:63];
	logic [39:0]        acc [0:63];
	logic signed [15:0] elu_lut [0:255];
	int unsigned        elem_cnt;
	logic [1:0]         act_mode;
	logic [6:0]         nin_reg;
	logic [6:0]         nn_reg;
	neuron_out_t        neuron_outputs_due [$];
	int                 mismatches;

	function new();
		logic [63:0] q;
		logic [63:0] r;
		foreach (weights[i]) weights[i] = '0;
		foreach (biases[i]) biases[i] = '0;
		foreach (acc[i]) acc[i] = '0;
		elem_cnt = 0;
		act_mode = dla_pkg::ACT_LINEAR;
		nin_reg = 7'd1;
		nn_reg = 7'd1;
		mismatches = 0;
		q = 64'h1_0000_0000;
		for (int k = 1; k <= 256; k++) begin
			q = (q * 64'd4162825044 + 64'h8000_0000) >> 32;
			r = (q + 64'h80_0000) >> 24;
			elu_lut[256 - k] = $signed(r[15:0]) - 16'sd256;
		end
	endfunction

	function int unsigned clamp_count(logic [6:0] r);
		if (r == 0) return 1;
		if (r > 64) return 64;
		return r;
	endfunction

	function void write_reg(logic [1:0] idx, logic [6:0] d);
		case (idx)
			dla_pkg::CFG_MODE: act_mode = d[1:0];
			dla_pkg::CFG_NIN:  nin_reg = d;
			dla_pkg::CFG_NN:   nn_reg = d;
			default:  ;
		endcase
	endfunction

	function void absorb_item(logic [1:0] k, logic [5:0] row, logic [5:0] nrn,
			logic signed [15:0] v);
		int unsigned        nin;
		int unsigned        nn;
		logic signed [31:0] prod;
		logic [39:0]        bsum;
		logic signed [63:0] full;
		logic signed [63:0] y;
		logic [7:0]         lut_i;
		neuron_out_t        e;
		nin = clamp_count(nin_reg);
		nn = clamp_count(nn_reg);
		case (k)
			dla_pkg::KIND_WEIGHT: weights[{row, nrn}] = v;
			dla_pkg::KIND_BIAS:   biases[nrn] = v;
			dla_pkg::KIND_ELEMENT: begin
				for (int n = 0; n < nn; n++) begin
					prod = weights[elem_cnt * 64 + n] * v;
					acc[n] = acc[n] + {{8{prod[31]}}, prod};
				end
				elem_cnt++;
				if (elem_cnt >= nin) begin
					for (int n = 0; n < nn; n++) begin
						bsum = acc[n] + {{16{biases[n][15]}}, biases[n], 8'h00};
						full = {{24{bsum[39]}}, bsum} + 64'd128;
						y = full >>> 8;
						if (y > 64'sd32767) y = 64'sd32767;
						else if (y < -64'sd32768) y = -64'sd32768;
						if (act_mode == dla_pkg::ACT_RELU) begin
							if (y < 0) y = 0;
						end else if (act_mode == dla_pkg::ACT_ELU) begin
							if (y < -64'sd2048) begin
								y = -64'sd256;
							end else if (y < 0) begin
								full = (y + 64'sd2048) >>> 3;
								lut_i = full[7:0];
								y = elu_lut[lut_i];
							end
						end
						e.nrn = n[5:0];
						e.val = y[15:0];
						e.last = (n == nn - 1);
						neuron_outputs_due.insert(neuron_outputs_due.size(), e);
					end
					foreach (acc[i]) acc[i] = '0;
					elem_cnt = 0;
				end
			end
			default: ;
		endcase
	endfunction

	task report(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task check_neuron(logic [5:0] nrn, logic signed [15:0] v, logic lst);
		neuron_out_t e;
		if (neuron_outputs_due.size() == 0) begin
			report($sformatf("neuron %0d value %0d arrived with nothing due", nrn, v));
			return;
		end
		e = neuron_outputs_due.pop_front();
		if (nrn !== e.nrn)
			report($sformatf("neuron index got %0d, want %0d", nrn, e.nrn));
		if (v !== e.val)
			report($sformatf("neuron %0d value got %0d, want %0d", e.nrn, v, e.val));
		if (lst !== e.last)
			report($sformatf("neuron %0d last got %0b, want %0b", e.nrn, lst, e.last));
	endtask
endclass

module tb;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_stall;
	logic [1:0]                            kind;
	logic [dla_pkg::IDX_W-1:0]             row_index;
	logic [dla_pkg::IDX_W-1:0]             neuron_index;
	logic signed [dla_pkg::DATA_WIDTH-1:0] value;
	logic                                  out_valid;
	logic                                  out_stall;
	logic [dla_pkg::IDX_W-1:0]             out_neuron;
	logic signed [dla_pkg::DATA_WIDTH-1:0] out_value;
	logic                                  out_last;
	logic                                  cfg_we;
	logic [1:0]                            cfg_index;
	logic [dla_pkg::CNT_W-1:0]             cfg_data;

	dense_layer_predictor layer = new();

	bit w_done [0:63][0:63];
	bit b_done [0:63];
	bit calm;
	bit hold_off_req;
	int elems_sent;

	dense_layer_with_activation_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.row_index    (row_index),
		.neuron_index (neuron_index),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_neuron   (out_neuron),
		.out_value    (out_value),
		.out_last     (out_last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			layer.absorb_item(kind, row_index, neuron_index, value);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			layer.check_neuron(out_neuron, out_value, out_last);
	end

	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: case ($urandom_range(0, 5))
				0:       return 16'sh7FFF;
				1:       return 16'sh8000;
				2:       return 16'sd0;
				3:       return -16'sd1;
				4:       return 16'sd256;
				default: return -16'sd256;
			endcase
			default: return 16'($signed($urandom_range(0, 1023)) - 512);
		endcase
	endfunction

	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(100, 600)) @(negedge clk);
			calm = !calm;
		end
	end

	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = 400;
			end else if (hold == 0 && $urandom_range(0, 2) == 0) begin
				hold = idle_len();
			end
			out_stall <= (hold != 0);
			if (hold != 0) hold--;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(logic [1:0] k, logic [5:0] r, logic [5:0] n,
			logic signed [15:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		row_index <= r;
		neuron_index <= n;
		value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic put_weight(logic [5:0] r, logic [5:0] n, logic signed [15:0] v);
		send_item(dla_pkg::KIND_WEIGHT, r, n, v);
		w_done[r][n] = 1'b1;
	endtask

	task automatic put_bias(logic [5:0] n, logic signed [15:0] v);
		send_item(dla_pkg::KIND_BIAS, 6'($urandom), n, v);
		b_done[n] = 1'b1;
	endtask

	// Fill any weight or bias this element would read before it was written.
	task automatic put_element(logic signed [15:0] v);
		int unsigned cnt;
		int unsigned nin;
		int unsigned nn;
		cnt = layer.elem_cnt;
		nin = layer.clamp_count(layer.nin_reg);
		nn = layer.clamp_count(layer.nn_reg);
		for (int n = 0; n < nn; n++)
			if (!w_done[cnt][n]) put_weight(6'(cnt), 6'(n), rand_val());
		if (cnt + 1 >= nin)
			for (int n = 0; n < nn; n++)
				if (!b_done[n]) put_bias(6'(n), rand_val());
		send_item(dla_pkg::KIND_ELEMENT, 6'($urandom), 6'($urandom), v);
		elems_sent++;
	endtask

	task automatic noise();
		case ($urandom_range(0, 2))
			0:       send_item(KIND_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
			1:       put_weight(6'($urandom), 6'($urandom), rand_val());
			default: put_bias(6'($urandom), rand_val());
		endcase
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (layer.neuron_outputs_due.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic set_regs(logic [6:0] md, logic [6:0] ni, logic [6:0] nn);
		logic [1:0] idx [4];
		logic [6:0] dat [4];
		idx = '{dla_pkg::CFG_MODE, dla_pkg::CFG_NIN, dla_pkg::CFG_NN, CFG_SPARE};
		dat = '{md, ni, nn, 7'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= dat[i];
			@(negedge clk);
			layer.write_reg(idx[i], dat[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [1:0] mode, logic [6:0] ni, logic [6:0] nn, int nvec,
			int cut, bit squeeze);
		int unsigned nin_e;
		int unsigned nn_e;
		int          total;
		settle();
		set_regs({5'($urandom), mode}, ni, nn);
		nin_e = layer.clamp_count(ni);
		nn_e = layer.clamp_count(nn);
		for (int r = 0; r < nin_e; r++)
			for (int n = 0; n < nn_e; n++)
				put_weight(6'(r), 6'(n), rand_val());
		for (int n = 0; n < nn_e; n++)
			put_bias(6'(n), rand_val());
		if (squeeze) hold_off_req = 1'b1;
		total = nvec * nin_e - cut;
		for (int e = 0; e < total; e++) begin
			if ($urandom_range(0, 11) == 0) noise();
			put_element(rand_val());
		end
	endtask

	initial begin
		int ni;
		int cut;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = dla_pkg::KIND_WEIGHT;
		row_index = '0;
		neuron_index = '0;
		value = '0;
		cfg_we = 1'b0;
		cfg_index = dla_pkg::CFG_MODE;
		cfg_data = '0;
		hold_off_req = 1'b0;
		elems_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// saturation both ways, exact floor, one-LSB results of either sign under reset settings
		send_item(KIND_NONE, 6'h3F, 6'h3F, -16'sd1);
		put_weight(6'd63, 6'd63, 16'sh8000);
		put_weight(6'd0, 6'd0, 16'sh7FFF);
		put_bias(6'd0, 16'sh8000);
		put_element(16'sh7FFF);
		put_element(16'sh8000);
		put_element(16'sd0);
		put_bias(6'd0, 16'sd0);
		put_weight(6'd0, 6'd0, 16'sd256);
		put_element(16'sd1);
		put_element(-16'sd1);
		settle();
		set_regs({5'($urandom), dla_pkg::ACT_RELU}, 7'd1, 7'd1);
		put_element(-16'sd1);
		put_element(16'sd300);
		settle();
		set_regs({5'($urandom), dla_pkg::ACT_ELU}, 7'd1, 7'd1);
		put_element(-16'sd2048);
		put_element(-16'sd2049);
		put_element(-16'sd1);
		put_element(-16'sd1000);
		put_element(16'sh8000);
		put_element(16'sd100);
		settle();
		set_regs({5'($urandom), ACT_SPARE}, 7'd1, 7'd1);
		put_element(-16'sd5);

		// zero counts, spare mode, a count change mid-vector, a long output hold
		run_phase(dla_pkg::ACT_RELU, 7'd0, 7'd3, 3, 0, 1'b0);
		run_phase(dla_pkg::ACT_ELU, 7'd2, 7'd0, 4, 0, 1'b0);
		run_phase(ACT_SPARE, 7'd5, 7'd2, 1, 2, 1'b0);
		run_phase(dla_pkg::ACT_ELU, 7'd1, 7'd8, 3, 0, 1'b1);

		elems_sent = 0;
		while (elems_sent < 12) begin
			ni = $urandom_range(1, 6);
			cut = ($urandom_range(0, 3) == 0 && ni > 1) ? $urandom_range(1, ni - 1) : 0;
			run_phase(2'($urandom), 7'(ni), 7'($urandom_range(1, 8)),
				$urandom_range(1, 4), cut, 1'b0);
		end

		settle();
		repeat (220) @(negedge clk);
		if (layer.mismatches == 0 && layer.neuron_outputs_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/dla_pkg.sv
hw/rtl/dla_store.sv
hw/rtl/dla_mac.sv
hw/rtl/dla_act.sv
hw/rtl/dense_layer_with_activation_unit.sv
hw/rtl/dla_checker.sv
sim/tb.sv
